// File: rtl/pnm_hp_pkg.sv
// Shared types for the PNM header parser: input item and result record.
`default_nettype none

package pnm_hp_pkg;

  // One byte of the file with its framing flags
  typedef struct packed {
    logic       stream_end;
    logic       stream_start;
    logic [7:0] data_byte;
  } item_t;

  // One parse result
  typedef struct packed {
    logic [31:0] image_height;
    logic [31:0] image_width;
    logic [1:0]  channels;
    logic [2:0]  format_digit;
    logic [1:0]  status;
  } result_t;

  localparam int unsigned ResultTdataW = 72;

endpackage

`default_nettype wire

// File: rtl/pnm_header_parser_top.sv
// Bytes pass from the input register through the parser into the result register.
// The parser takes one byte per cycle while the result register can take a result.
// While a result waits in the output register the input register takes one more byte,
// then the input stalls until that result transfer completes.
// Reset (synchronous, active high) empties both registers and returns the parser
// to waiting for the first magic byte.
`default_nettype none

module pnm_header_parser_top (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire  [0:0]  s_axis_tuser,   // [0] stream_start
  input  wire         s_axis_tlast,   // stream_end
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [pnm_hp_pkg::ResultTdataW-1:0] m_axis_tdata, // [2:0] format_digit,
                                      // [4:3] channels, [36:5] image_width,
                                      // [68:37] image_height, [71:69] zero
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  pnm_hp_pkg::item_t   in_item;
  pnm_hp_pkg::item_t   held_item;
  pnm_hp_pkg::result_t core_res;
  pnm_hp_pkg::result_t out_res;
  logic                held_valid;
  logic                advance;
  logic                fire;
  logic                res_push;

  // Pack the incoming transfer
  assign in_item.data_byte    = s_axis_tdata;
  assign in_item.stream_start = s_axis_tuser[0];
  assign in_item.stream_end   = s_axis_tlast;

  // Move the held byte on whenever the result register can take a result
  assign advance = !m_axis_tvalid || m_axis_tready;
  assign fire    = held_valid && advance;

  pnm_hp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (in_item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  pnm_hp_core u_core (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .item     (held_item),
    .res_push (res_push),
    .res      (core_res)
  );

  pnm_hp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_res  (core_res),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_res   (out_res)
  );

  // Unpack the result onto the output bus
  assign m_axis_tuser = out_res.status;
  assign m_axis_tdata = {3'b000, out_res.image_height, out_res.image_width,
                         out_res.channels, out_res.format_digit};

endmodule

`default_nettype wire

// File: rtl/pnm_hp_in_stage.sv
// Input register: holds one accepted byte until the parser takes it.
`default_nettype none

module pnm_hp_in_stage (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire pnm_hp_pkg::item_t in_item,
  input  wire                    advance,
  output logic                   held_valid,
  output pnm_hp_pkg::item_t      held_item
);

  // Accept when empty or when the held byte moves on this cycle
  assign in_ready = !held_valid || advance;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_item <= in_item;
    end
  end

endmodule

`default_nettype wire

// File: rtl/pnm_hp_core.sv
// Parser state and the per-byte state update that produces results.
`default_nettype none

module pnm_hp_core (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    fire,
  input  wire pnm_hp_pkg::item_t item,
  output logic                   res_push,
  output pnm_hp_pkg::result_t    res
);

  localparam logic [2:0] PH_MAGIC_P     = 3'd0;
  localparam logic [2:0] PH_MAGIC_DIGIT = 3'd1;
  localparam logic [2:0] PH_MAGIC_SPACE = 3'd2;
  localparam logic [2:0] PH_SKIP_W      = 3'd3;
  localparam logic [2:0] PH_WIDTH       = 3'd4;
  localparam logic [2:0] PH_SKIP_H      = 3'd5;
  localparam logic [2:0] PH_HEIGHT      = 3'd6;
  localparam logic [2:0] PH_DONE        = 3'd7;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MAGIC   = 2'd1;
  localparam logic [1:0] ST_TRUNC   = 2'd2;

  localparam logic [7:0] CH_P       = 8'h50;
  localparam logic [7:0] CH_ONE     = 8'h31;
  localparam logic [7:0] CH_SIX     = 8'h36;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_NL      = 8'h0a;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0d;

  logic [2:0]  phase, phase_next;
  logic        in_comment, in_comment_next;
  logic [2:0]  magic_digit, magic_digit_next;
  logic [31:0] width_acc, width_acc_next;
  logic [31:0] height_acc, height_acc_next;

  logic        emit;
  logic        used;
  logic        is_ws;
  logic        is_dig;
  logic [7:0]  b;
  logic [3:0]  digit;

  // Multiply by ten and add one digit, saturating at the 32-bit maximum
  function automatic logic [31:0] acc_digit(input logic [31:0] acc, input logic [3:0] d);
    logic [35:0] v;
    v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {32'd0, d};
    return (v[35:32] != 4'd0) ? 32'hffff_ffff : v[31:0];
  endfunction

  // Channel count of a format digit
  function automatic logic [1:0] chan_of(input logic [2:0] d);
    logic [1:0] c;
    if (d == 3'd0) begin
      c = 2'd0;
    end else if (d == 3'd3 || d == 3'd6) begin
      c = 2'd3;
    end else begin
      c = 2'd1;
    end
    return c;
  endfunction

  assign b      = item.data_byte;
  assign digit  = b[3:0];
  assign is_ws  = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  assign is_dig = (b >= CH_ZERO) && (b <= CH_NINE);

  // Work out the next state and any result for the byte at hand
  always_comb begin
    phase_next       = item.stream_start ? PH_MAGIC_P : phase;
    in_comment_next  = item.stream_start ? 1'b0 : in_comment;
    magic_digit_next = item.stream_start ? 3'd0 : magic_digit;
    width_acc_next   = item.stream_start ? 32'd0 : width_acc;
    height_acc_next  = item.stream_start ? 32'd0 : height_acc;
    emit             = 1'b0;
    used             = 1'b0;
    res              = '0;

    if (phase_next != PH_DONE) begin
      // Comment bytes and the three magic bytes
      if (in_comment_next) begin
        if (b == CH_NL) begin
          in_comment_next = 1'b0;
        end
        used = 1'b1;
      end else if (phase_next == PH_MAGIC_P) begin
        used = 1'b1;
        if (b != CH_P) begin
          emit       = 1'b1;
          res.status = ST_MAGIC;
        end else begin
          phase_next = PH_MAGIC_DIGIT;
        end
      end else if (phase_next == PH_MAGIC_DIGIT) begin
        used = 1'b1;
        if (b < CH_ONE || b > CH_SIX) begin
          emit       = 1'b1;
          res.status = ST_MAGIC;
        end else begin
          magic_digit_next = b[2:0];
          phase_next       = PH_MAGIC_SPACE;
        end
      end else if (phase_next == PH_MAGIC_SPACE) begin
        used = 1'b1;
        if (!is_ws) begin
          emit       = 1'b1;
          res.status = ST_MAGIC;
        end else begin
          phase_next = PH_SKIP_W;
        end
      end

      // Skip before width
      if (!used && phase_next == PH_SKIP_W) begin
        if (b == CH_HASH) begin
          in_comment_next = 1'b1;
          used            = 1'b1;
        end else if (is_ws) begin
          used = 1'b1;
        end else begin
          phase_next = PH_WIDTH;
        end
      end

      // Width digits
      if (!used && phase_next == PH_WIDTH) begin
        if (is_dig) begin
          width_acc_next = acc_digit(width_acc_next, digit);
          used           = 1'b1;
        end else if (b == CH_HASH) begin
          in_comment_next = 1'b1;
          used            = 1'b1;
        end else begin
          phase_next = PH_SKIP_H;
        end
      end

      // Skip before height
      if (!used && phase_next == PH_SKIP_H) begin
        if (b == CH_HASH) begin
          in_comment_next = 1'b1;
          used            = 1'b1;
        end else if (is_ws) begin
          used = 1'b1;
        end else begin
          phase_next = PH_HEIGHT;
        end
      end

      // Height digits; a hash starts a comment, any other byte ends the header
      if (!used && phase_next == PH_HEIGHT) begin
        if (is_dig) begin
          height_acc_next = acc_digit(height_acc_next, digit);
        end else if (b == CH_HASH) begin
          in_comment_next = 1'b1;
        end else begin
          emit             = 1'b1;
          res.status       = ST_OK;
          res.format_digit = magic_digit_next;
          res.channels     = chan_of(magic_digit_next);
          res.image_width  = width_acc_next;
          res.image_height = height_acc_next;
        end
      end

      // End of stream before a result
      if (!emit && item.stream_end) begin
        emit = 1'b1;
        if (phase_next <= PH_MAGIC_SPACE) begin
          res.status = ST_MAGIC;
        end else begin
          res.status       = ST_TRUNC;
          res.format_digit = magic_digit_next;
          res.channels     = chan_of(magic_digit_next);
        end
      end

      if (emit) begin
        phase_next = PH_DONE;
      end
    end
  end

  assign res_push = fire && emit;

  // Advance the parser state on each byte taken
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_MAGIC_P;
      in_comment  <= 1'b0;
      magic_digit <= 3'd0;
      width_acc   <= 32'd0;
      height_acc  <= 32'd0;
    end else if (fire) begin
      phase       <= phase_next;
      in_comment  <= in_comment_next;
      magic_digit <= magic_digit_next;
      width_acc   <= width_acc_next;
      height_acc  <= height_acc_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/pnm_hp_out_stage.sv
// Result register: holds one result until the downstream side takes it.
`default_nettype none

module pnm_hp_out_stage (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      push,
  input  wire pnm_hp_pkg::result_t push_res,
  input  wire                      out_ready,
  output logic                     out_valid,
  output pnm_hp_pkg::result_t      out_res
);

  // Valid flag: load on push, drop once the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (push) begin
      out_res <= push_res;
    end
  end

endmodule

`default_nettype wire
